[rtl/core/srr_pkg.sv]
// Shared types and constants for the selective-repeat receiver.
// Used by every module under rtl/core except srr_fifo; no dependencies.
package srr_pkg;

   localparam int unsigned SEQ_COUNT_DEF   = 20;
   localparam int unsigned WINDOW_DEF      = 7;
   localparam int unsigned MAX_PAYLOAD_DEF = 1024;
   localparam int unsigned MAX_RESULTS     = 8;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned TAG_W  = 16;
   localparam int unsigned LEN_W  = 11;
   localparam int unsigned KIND_W = 2;

   localparam int unsigned CMD_DEPTH = 2;
   localparam int unsigned RSP_DEPTH = 8;

   localparam logic [CODE_W-1:0] CODE_HANDSHAKE = 8'd205;
   localparam logic [CODE_W-1:0] CODE_HS_REPLY  = 8'd200;
   localparam logic [CODE_W-1:0] CODE_END       = 8'hFF;

   localparam logic [KIND_W-1:0] KIND_HS_REPLY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EOF      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DATA     = 2'd3;

   // classified frame handed from front to back
   typedef struct packed {
      logic              is_hs;
      logic              is_end;
      logic [CODE_W-1:0] seq;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] reply_code;
      logic [TAG_W-1:0]  out_tag;
      logic [LEN_W-1:0]  out_len;
      logic              last;
   } rsp_type;

endpackage

[rtl/core/selective_repeat_receiver.sv]
// Selective-repeat receiver top level: front end, command queue, back end,
// result queue. A result reaches the rsp_ ports through the front-end register,
// the command queue and the result queue, a released word also through the back
// end's release state. A frame at the window base releases a run of 1..7 words,
// one word per cycle while the result queue has room, then its ack. Synchronous
// reset empties both queues, returns to the handshake stage and clears all marks.
module selective_repeat_receiver #(
   parameter int unsigned SEQ_COUNT   = srr_pkg::SEQ_COUNT_DEF,
   parameter int unsigned WINDOW      = srr_pkg::WINDOW_DEF,
   parameter int unsigned MAX_PAYLOAD = srr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [srr_pkg::CODE_W-1:0]  req_frame_code,
   input  logic [srr_pkg::TAG_W-1:0]   req_payload_tag,
   input  logic [srr_pkg::LEN_W-1:0]   req_payload_len,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [srr_pkg::KIND_W-1:0]  rsp_kind,
   output logic [srr_pkg::CODE_W-1:0]  rsp_reply_code,
   output logic [srr_pkg::TAG_W-1:0]   rsp_out_tag,
   output logic [srr_pkg::LEN_W-1:0]   rsp_out_len,
   output logic                        rsp_last
);

   srr_pkg::cmd_type cmd_wr_data, cmd_rd_data;
   srr_pkg::rsp_type rsp_wr_data, rsp_rd_data;
   logic             cmd_wr_en, cmd_full, cmd_rd_en, cmd_empty;
   logic             rsp_wr_en, rsp_full;

   srr_front #(
      .SEQ_COUNT   (SEQ_COUNT),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_frame_code  (req_frame_code),
      .req_payload_tag (req_payload_tag),
      .req_payload_len (req_payload_len),
      .cmd_wr_en       (cmd_wr_en),
      .cmd_data        (cmd_wr_data),
      .cmd_full        (cmd_full)
   );

   srr_fifo #(
      .WIDTH ($bits(srr_pkg::cmd_type)),
      .DEPTH (srr_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr_en),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .rd_en   (cmd_rd_en),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   srr_back #(
      .SEQ_COUNT (SEQ_COUNT),
      .WINDOW    (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd_data),
      .cmd_rd_en (cmd_rd_en),
      .rsp_full  (rsp_full),
      .rsp_wr_en (rsp_wr_en),
      .rsp_data  (rsp_wr_data)
   );

   srr_fifo #(
      .WIDTH ($bits(srr_pkg::rsp_type)),
      .DEPTH (srr_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr_en),
      .wr_data (rsp_wr_data),
      .full    (rsp_full),
      .rd_en   (rsp_pop),
      .rd_data (rsp_rd_data),
      .empty   (rsp_empty)
   );

   assign rsp_kind       = rsp_rd_data.kind;
   assign rsp_reply_code = rsp_rd_data.reply_code;
   assign rsp_out_tag    = rsp_rd_data.out_tag;
   assign rsp_out_len    = rsp_rd_data.out_len;
   assign rsp_last       = rsp_rd_data.last;

endmodule

[rtl/core/srr_fifo.sv]
// Small flop-based first-word-fall-through queue.
// Generic; used for the command queue and the result queue.
module srr_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   always_comb begin
      do_wr = wr_en && !full;
      do_rd = rd_en && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

endmodule

[rtl/core/srr_front.sv]
// Front end: takes frames, reduces the code to a sequence number, clamps
// the length and classifies the frame. Depends on srr_pkg.
module srr_front #(
   parameter int unsigned SEQ_COUNT   = srr_pkg::SEQ_COUNT_DEF,
   parameter int unsigned MAX_PAYLOAD = srr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [srr_pkg::CODE_W-1:0]  req_frame_code,
   input  logic [srr_pkg::TAG_W-1:0]   req_payload_tag,
   input  logic [srr_pkg::LEN_W-1:0]   req_payload_len,
   output logic                        cmd_wr_en,
   output srr_pkg::cmd_type            cmd_data,
   input  logic                        cmd_full
);

   // reciprocal estimate of code / SEQ_COUNT, low by at most one
   localparam logic [15:0] RECIP = 16'(65536 / SEQ_COUNT);

   logic                       valid_ff, valid_in;
   logic [srr_pkg::CODE_W-1:0] code_ff;
   logic [srr_pkg::CODE_W-1:0] quot_ff;
   logic [srr_pkg::TAG_W-1:0]  tag_ff;
   logic [srr_pkg::LEN_W-1:0]  len_ff;
   logic                       accept;
   logic [23:0]                prod;
   logic [srr_pkg::LEN_W-1:0]  len_sat;
   logic [15:0]                rem_wide;
   logic [15:0]                rem_fix;

   always_comb begin
      accept   = req_push && !req_full;
      valid_in = accept || (valid_ff && cmd_full);
      prod     = 24'(req_frame_code) * 24'(RECIP);
      len_sat  = (32'(req_payload_len) > MAX_PAYLOAD) ? srr_pkg::LEN_W'(MAX_PAYLOAD)
                                                       : req_payload_len;
      rem_wide = 16'(code_ff) - 16'(quot_ff) * 16'(SEQ_COUNT);
      rem_fix  = (rem_wide >= 16'(SEQ_COUNT)) ? rem_wide - 16'(SEQ_COUNT) : rem_wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= req_frame_code;
         quot_ff <= prod[23:16];
         tag_ff  <= req_payload_tag;
         len_ff  <= len_sat;
      end
   end

   assign req_full        = valid_ff && cmd_full;
   assign cmd_wr_en       = valid_ff;
   assign cmd_data.is_hs  = (code_ff == srr_pkg::CODE_HANDSHAKE);
   assign cmd_data.is_end = (code_ff == srr_pkg::CODE_END);
   assign cmd_data.seq    = rem_fix[srr_pkg::CODE_W-1:0];
   assign cmd_data.tag    = tag_ff;
   assign cmd_data.len    = len_ff;

endmodule

[rtl/core/srr_back.sv]
// Back end: stage and window state, slot store, in-order release of the
// received run and all replies. Depends on srr_pkg.
module srr_back #(
   parameter int unsigned SEQ_COUNT = srr_pkg::SEQ_COUNT_DEF,
   parameter int unsigned WINDOW    = srr_pkg::WINDOW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  srr_pkg::cmd_type cmd_data,
   output logic             cmd_rd_en,
   input  logic             rsp_full,
   output logic             rsp_wr_en,
   output srr_pkg::rsp_type rsp_data
);

   localparam int unsigned SEQ_W  = $clog2(SEQ_COUNT);
   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned RUN_W  = $clog2(srr_pkg::MAX_RESULTS);
   localparam int unsigned CMP_W  = (SEQ_W + 1 > 6) ? SEQ_W + 1 : 6;
   localparam int unsigned LIM_A  = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
   localparam int unsigned RUN_LIMIT =
      (LIM_A < srr_pkg::MAX_RESULTS - 1) ? LIM_A : srr_pkg::MAX_RESULTS - 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RELEASE,
      ST_ACK
   } state_type;

   state_type                  state_ff, state_in;
   logic                       stage_ff, stage_in;
   logic [SEQ_W-1:0]           base_ff, base_in;
   logic [SLOT_W-1:0]          slot_base_ff, slot_base_in;
   logic [SEQ_COUNT-1:0]       marks_ff, marks_in;
   logic [RUN_W-1:0]           run_ff, run_in;
   logic [SEQ_W-1:0]           ack_seq_ff, ack_seq_in;
   logic [srr_pkg::TAG_W-1:0]  slot_tag_ff [WINDOW];
   logic [srr_pkg::LEN_W-1:0]  slot_len_ff [WINDOW];

   logic [SEQ_W-1:0]  cmd_seq;
   logic [SEQ_W:0]    dist_sum;
   logic [SEQ_W:0]    seq_off;
   logic              in_window;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] slot_idx;
   logic              slot_we;
   logic [SEQ_W-1:0]  base_next;
   logic [SLOT_W-1:0] slot_next;
   logic [RUN_W-1:0]  run_next;
   logic              run_more;

   always_comb begin
      cmd_seq   = cmd_data.seq[SEQ_W-1:0];
      dist_sum  = {1'b0, cmd_seq} + (SEQ_W + 1)'(SEQ_COUNT) - {1'b0, base_ff};
      seq_off   = (dist_sum >= (SEQ_W + 1)'(SEQ_COUNT))
                  ? dist_sum - (SEQ_W + 1)'(SEQ_COUNT) : dist_sum;
      in_window = (CMP_W'(seq_off) < CMP_W'(WINDOW)) && !marks_ff[cmd_seq];
      slot_sum  = (SLOT_W + 1)'(slot_base_ff) + (SLOT_W + 1)'(seq_off);
      slot_idx  = (slot_sum >= (SLOT_W + 1)'(WINDOW))
                  ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW)) : SLOT_W'(slot_sum);
      base_next = (base_ff == SEQ_W'(SEQ_COUNT - 1)) ? '0 : base_ff + 1'b1;
      slot_next = (slot_base_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_base_ff + 1'b1;
      run_next  = run_ff + 1'b1;
      run_more  = (run_next < RUN_W'(RUN_LIMIT)) && marks_ff[base_next];
   end

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      base_in      = base_ff;
      slot_base_in = slot_base_ff;
      marks_in     = marks_ff;
      run_in       = run_ff;
      ack_seq_in   = ack_seq_ff;
      slot_we      = 1'b0;
      cmd_rd_en    = 1'b0;
      rsp_wr_en    = 1'b0;
      rsp_data     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_rd_en = 1'b1;
               if (!stage_ff) begin
                  // anything but the handshake code is dropped here
                  if (cmd_data.is_hs) begin
                     stage_in        = 1'b1;
                     base_in         = '0;
                     slot_base_in    = '0;
                     marks_in        = '0;
                     rsp_wr_en       = 1'b1;
                     rsp_data.kind   = srr_pkg::KIND_HS_REPLY;
                     rsp_data.reply_code = srr_pkg::CODE_HS_REPLY;
                     rsp_data.last   = 1'b1;
                  end
               end else if (cmd_data.is_end) begin
                  stage_in      = 1'b0;
                  rsp_wr_en     = 1'b1;
                  rsp_data.kind = srr_pkg::KIND_EOF;
                  rsp_data.last = 1'b1;
               end else begin
                  if (in_window) begin
                     slot_we           = 1'b1;
                     marks_in[cmd_seq] = 1'b1;
                  end
                  if (in_window && seq_off == '0) begin
                     ack_seq_in = cmd_seq;
                     run_in     = '0;
                     state_in   = ST_RELEASE;
                  end else begin
                     rsp_wr_en           = 1'b1;
                     rsp_data.kind       = srr_pkg::KIND_ACK;
                     rsp_data.reply_code = srr_pkg::CODE_W'(cmd_seq);
                     rsp_data.last       = 1'b1;
                  end
               end
            end
         end
         ST_RELEASE: begin
            // one buffered word per cycle while the result queue is not full, oldest first
            if (!rsp_full) begin
               rsp_wr_en         = 1'b1;
               rsp_data.kind     = srr_pkg::KIND_DATA;
               rsp_data.out_tag  = slot_tag_ff[slot_base_ff];
               rsp_data.out_len  = slot_len_ff[slot_base_ff];
               marks_in[base_ff] = 1'b0;
               base_in           = base_next;
               slot_base_in      = slot_next;
               run_in            = run_next;
               if (!run_more) begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (!rsp_full) begin
               rsp_wr_en           = 1'b1;
               rsp_data.kind       = srr_pkg::KIND_ACK;
               rsp_data.reply_code = srr_pkg::CODE_W'(ack_seq_ff);
               rsp_data.last       = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= 1'b0;
         base_ff      <= '0;
         slot_base_ff <= '0;
         marks_ff     <= '0;
         run_ff       <= '0;
         ack_seq_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         base_ff      <= base_in;
         slot_base_ff <= slot_base_in;
         marks_ff     <= marks_in;
         run_ff       <= run_in;
         ack_seq_ff   <= ack_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_tag_ff[slot_idx] <= cmd_data.tag;
         slot_len_ff[slot_idx] <= cmd_data.len;
      end
   end

endmodule

[rtl/core/srr_checker.sv]
// Port-level checks for selective_repeat_receiver, bound to the top level.
// Depends on srr_pkg.
module srr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_push,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [srr_pkg::KIND_W-1:0] rsp_kind,
   input logic [srr_pkg::CODE_W-1:0] rsp_reply_code,
   input logic [srr_pkg::TAG_W-1:0]  rsp_out_tag,
   input logic [srr_pkg::LEN_W-1:0]  rsp_out_len,
   input logic                       rsp_last
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_kind)
         && $stable(rsp_reply_code) && $stable(rsp_out_tag)
         && $stable(rsp_out_len) && $stable(rsp_last))
      else $error("waiting result word changed");

   a_hs_reply: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_kind == srr_pkg::KIND_HS_REPLY |->
         rsp_reply_code == srr_pkg::CODE_HS_REPLY && rsp_last
         && rsp_out_tag == '0 && rsp_out_len == '0)
      else $error("malformed handshake reply");

   a_data_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_kind == srr_pkg::KIND_DATA |->
         !rsp_last && rsp_reply_code == '0)
      else $error("delivered payload word marked last or coded");

   a_ack_eof_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_kind == srr_pkg::KIND_ACK || rsp_kind == srr_pkg::KIND_EOF)
         |-> rsp_last && rsp_out_tag == '0 && rsp_out_len == '0)
      else $error("ack or end-of-file reply not last");

endmodule

bind selective_repeat_receiver srr_checker u_checker (.*);

[tb/sv/tb_selective_repeat_receiver.sv]
// Self-checking bench for selective_repeat_receiver: frames in, words out.
// It predicts the reply, ack and delivered words for each accepted frame and
// compares them in order. Depends on srr_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_selective_repeat_receiver;
   import srr_pkg::*;

   localparam int unsigned SEQ         = SEQ_COUNT_DEF;
   localparam int unsigned WIN         = WINDOW_DEF;
   localparam int unsigned MAXP        = MAX_PAYLOAD_DEF;
   localparam int unsigned RUN_LIMIT   = (WIN < SEQ ? WIN : SEQ) < MAX_RESULTS - 1 ?
                                         (WIN < SEQ ? WIN : SEQ) : MAX_RESULTS - 1;
   localparam int unsigned RANDOM_ITEMS = 185;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned SETTLE       = 40;

   // Receive-window predictor plus the queue of words still owed by the block.
   class srr_scoreboard;
      bit              in_transfer;
      int unsigned     base;
      int unsigned     slot0;
      bit              marks[SEQ];
      logic [TAG_W-1:0] tags[WIN];
      logic [LEN_W-1:0] lens[WIN];
      rsp_type         owed[$];
      int unsigned     errors;

      function new();
         in_transfer = 1'b0;
         base = 0;
         slot0 = 0;
         errors = 0;
         foreach (marks[i]) marks[i] = 1'b0;
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%s", what);
      endfunction

      function void owe(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                        logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic last);
         rsp_type w;
         w.kind = kind;
         w.reply_code = code;
         w.out_tag = tag;
         w.out_len = len;
         w.last = last;
         owed.push_back(w);
      endfunction

      function void note_frame(logic [CODE_W-1:0] code, logic [TAG_W-1:0] tag,
                               logic [LEN_W-1:0] len);
         int unsigned seq, seq_off, slot, run, s;
         if (!in_transfer) begin
            // anything but a handshake is dropped silently here
            if (code != CODE_HANDSHAKE) return;
            base = 0;
            slot0 = 0;
            foreach (marks[i]) marks[i] = 1'b0;
            in_transfer = 1'b1;
            owe(KIND_HS_REPLY, CODE_HS_REPLY, '0, '0, 1'b1);
            return;
         end
         if (code == CODE_END) begin
            in_transfer = 1'b0;
            owe(KIND_EOF, '0, '0, '0, 1'b1);
            return;
         end
         seq = code % SEQ;
         seq_off = (seq + SEQ - base) % SEQ;
         if (seq_off < WIN && !marks[seq]) begin
            slot = (slot0 + seq_off) % WIN;
            tags[slot] = tag;
            lens[slot] = (len > MAXP) ? LEN_W'(MAXP) : len;
            marks[seq] = 1'b1;
            if (seq_off == 0) begin
               run = 1;
               while (run < RUN_LIMIT && marks[(base + run) % SEQ]) run++;
               for (int unsigned i = 0; i < run; i++) begin
                  s = (slot0 + i) % WIN;
                  owe(KIND_DATA, '0, tags[s], lens[s], 1'b0);
                  marks[(base + i) % SEQ] = 1'b0;
               end
               slot0 = (slot0 + run) % WIN;
               base = (base + run) % SEQ;
            end
         end
         owe(KIND_ACK, CODE_W'(seq), '0, '0, 1'b1);
      endfunction

      function void check_word(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                               logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic last);
         rsp_type w;
         if (owed.size() == 0) begin
            flag($sformatf("unexpected word: kind %0d code %0d tag %h len %0d last %b",
                           kind, code, tag, len, last));
            return;
         end
         w = owed.pop_front();
         if (kind !== w.kind || code !== w.reply_code || tag !== w.out_tag ||
             len !== w.out_len || last !== w.last)
            flag($sformatf({"word mismatch: exp kind %0d code %0d tag %h len %0d last %b,",
                            " got kind %0d code %0d tag %h len %0d last %b"},
                           w.kind, w.reply_code, w.out_tag, w.out_len, w.last,
                           kind, code, tag, len, last));
      endfunction

      function void close();
         if (owed.size() != 0)
            flag($sformatf("%0d words never delivered", owed.size()));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [CODE_W-1:0]  req_frame_code = '0;
   logic [TAG_W-1:0]   req_payload_tag = '0;
   logic [LEN_W-1:0]   req_payload_len = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [KIND_W-1:0]  rsp_kind;
   logic [CODE_W-1:0]  rsp_reply_code;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [LEN_W-1:0]   rsp_out_len;
   logic               rsp_last;

   srr_scoreboard sb;
   bit            tx_fast = 1'b0;
   bit            rx_fast = 1'b0;
   int unsigned   cycles = 0;

   selective_repeat_receiver DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_frame_code  (req_frame_code),
      .req_payload_tag (req_payload_tag),
      .req_payload_len (req_payload_len),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_reply_code  (rsp_reply_code),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_len     (rsp_out_len),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // both handshakes are observed at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.note_frame(req_frame_code, req_payload_tag, req_payload_len);
         if (rsp_pop && !rsp_empty)
            sb.check_word(rsp_kind, rsp_reply_code, rsp_out_tag, rsp_out_len, rsp_last);
      end
   end

   // ends on the falling edge where the next word may be raised
   task automatic wait_gap();
      int unsigned gap;
      gap = tx_fast ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic push_frame(input logic [CODE_W-1:0] code, input logic [TAG_W-1:0] tag,
                             input logic [LEN_W-1:0] len);
      req_push <= 1'b1;
      req_frame_code <= code;
      req_payload_tag <= tag;
      req_payload_len <= len;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send(input logic [CODE_W-1:0] code, input logic [TAG_W-1:0] tag,
                       input logic [LEN_W-1:0] len);
      wait_gap();
      push_frame(code, tag, len);
   endtask

   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rx_fast ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
      end
   end

   initial begin
      int unsigned      items;
      int unsigned      pick;
      bit               counted;
      bit               was_end;
      logic [CODE_W-1:0] code;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;

      sb = new();
      items = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // ignored before handshake, then the handshake itself
      send(8'd0, 16'h0000, 11'd0);
      send(CODE_END, 16'hFFFF, 11'd2047);
      send(CODE_HS_REPLY, 16'h5A5A, 11'd5);
      send(CODE_HANDSHAKE, 16'h0001, 11'd1);
      // out of order fill, saturation, duplicate, then in-order release
      send(8'd1, 16'hFFFF, 11'd2047);
      send(8'd2, 16'h1234, 11'd1024);
      send(8'd1, 16'hDEAD, 11'd3);
      send(8'd0, 16'h0000, 11'd1025);
      send(8'd10, 16'hBEEF, 11'd7);          // beyond the window
      send(8'd2, 16'hCAFE, 11'd8);           // behind the window
      send(8'd24, 16'h0444, 11'd44);         // reduced to 4
      send(CODE_HANDSHAKE, 16'h0555, 11'd55); // plain seq 5 while transferring
      send(8'd6, 16'h0666, 11'd66);
      send(8'd7, 16'h0777, 11'd77);
      send(8'd8, 16'h0888, 11'd88);
      send(8'd9, 16'h0999, 11'd99);
      send(8'd3, 16'h0333, 11'd33);          // full-window release
      send(8'd254, 16'h8001, 11'd1);         // 254 mod 20 lands on 14
      send(CODE_END, 16'h0000, 11'd0);
      send(CODE_HANDSHAKE, 16'h0000, 11'd0);
      send(8'd0, 16'h0000, 11'd0);
      send(8'd19, 16'h7FFF, 11'd1023);
      send(CODE_END, 16'h0000, 11'd0);
      drain();

      while (items < RANDOM_ITEMS) begin
         wait_gap();
         pick = $urandom_range(0, 99);
         if (!sb.in_transfer) begin
            code = (pick < 80) ? CODE_HANDSHAKE : CODE_W'($urandom_range(0, 255));
         end else begin
            if (pick < 4) code = CODE_END;
            else if (pick < 74) code = CODE_W'((sb.base + $urandom_range(0, WIN - 1)) % SEQ);
            else if (pick < 88) code = CODE_W'((sb.base + $urandom_range(WIN, SEQ - 1)) % SEQ);
            else code = CODE_W'($urandom_range(0, 254));
            // alias onto a higher code with the same residue
            if (pick >= 4 && pick < 88 && $urandom_range(0, 3) == 0)
               code = CODE_W'(code + SEQ * $urandom_range(0, (254 - code) / SEQ));
         end
         counted = sb.in_transfer || code == CODE_HANDSHAKE;
         was_end = sb.in_transfer && code == CODE_END;
         tag = TAG_W'($urandom);
         len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(MAXP + 1, 2047))
                                           : LEN_W'($urandom_range(0, MAXP));
         push_frame(code, tag, len);
         if (counted) items++;
         if (was_end && $urandom_range(0, 2) == 0) drain();
         if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
      end

      drain();
      repeat (SETTLE) @(negedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
rtl/core/srr_pkg.sv
rtl/core/srr_fifo.sv
rtl/core/srr_front.sv
rtl/core/srr_back.sv
rtl/core/selective_repeat_receiver.sv
rtl/core/srr_checker.sv
tb/sv/tb_selective_repeat_receiver.sv
